// ----- design/rgba_layer_blend_core_assert.svh -----
// Assertion macros for the RGBA layer blend core.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef RGBA_LAYER_BLEND_CORE_ASSERT_SVH
`define RGBA_LAYER_BLEND_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check with reset masking
`define RLB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds during reset
`define RLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLB_ASSERT(lbl, clk, rstn, prop, msg)
`define RLB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/rlb_pkg.sv -----
// Shared types and codes for the RGBA layer blend core.
// No dependencies.
package rlb_pkg;

  typedef logic [7:0] px_t;

  // blend mode codes
  localparam logic [3:0] MODE_NORMAL    = 4'd0;
  localparam logic [3:0] MODE_ADD       = 4'd1;
  localparam logic [3:0] MODE_SUBTRACT  = 4'd2;
  localparam logic [3:0] MODE_MULTIPLY  = 4'd3;
  localparam logic [3:0] MODE_SCREEN    = 4'd4;
  localparam logic [3:0] MODE_MAX       = 4'd5;
  localparam logic [3:0] MODE_MIN       = 4'd6;
  localparam logic [3:0] MODE_AVERAGE   = 4'd7;
  localparam logic [3:0] MODE_SHADOW    = 4'd8;
  localparam logic [3:0] MODE_HIGHLIGHT = 4'd9;

  // register indexes
  localparam logic REG_BLEND_MODE  = 1'b0;
  localparam logic REG_BLEND_VALUE = 1'b1;

  // Q1.16 one, and the transparency threshold (about 0.001)
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] ALPHA_EPS_Q16 = 17'd65;

  // side data that rides along the divider
  typedef struct packed {
    logic          use_div;
    px_t           div_a;
    logic [3:0][7:0] alt;
  } rlb_side_t;

endpackage

// ----- design/rlb_front.sv -----
// Front pipeline: opacity and alpha math, simple blend modes, normal-mode numerators.
// Six register stages; depends on rlb_pkg.
module rlb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [3:0][7:0]     dst,
  input  logic [3:0][7:0]     src,
  input  logic [3:0]          mode,
  input  logic [16:0]         op,
  output logic                out_vld,
  output logic [2:0][24:0]    num,
  output logic [16:0]         oa,
  output rlb_pkg::rlb_side_t  side
);
  import rlb_pkg::*;

  // x/255 estimate, low by at most one
  function automatic logic [16:0] div255_est(input logic [23:0] x);
    logic [39:0] t;
    t = ({16'b0, x} << 15) + ({16'b0, x} << 7);
    return t[39:23];
  endfunction

  // one correction step for the estimate
  function automatic logic [16:0] div255_fix(input logic [23:0] x, input logic [16:0] q0);
    logic [25:0] r;
    r = {2'b0, x} - ({1'b0, q0, 8'b0} - {9'b0, q0});
    return (r >= 26'd255) ? q0 + 17'd1 : q0;
  endfunction

  // ---------------- stage 1: products ----------------
  logic            s1_vld_r;
  logic [3:0][7:0] s1_d_r, s1_s_r;
  logic [3:0]      s1_mode_r;
  logic [23:0]     s1_psa_r;
  logic [2:0][23:0] s1_pso_r;
  logic [2:0][15:0] s1_pds_r, s1_pscr_r;
  logic [24:0]     psa_nxt;
  logic [2:0][24:0] pso_nxt;

  always_comb begin
    psa_nxt = {17'b0, src[3]} * {8'b0, op};
    for (int i = 0; i < 3; i++) begin
      pso_nxt[i] = {17'b0, src[i]} * {8'b0, op};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d_r    <= dst;
      s1_s_r    <= src;
      s1_mode_r <= mode;
      s1_psa_r  <= psa_nxt[23:0];
      for (int i = 0; i < 3; i++) begin
        s1_pso_r[i]  <= pso_nxt[i][23:0];
        s1_pds_r[i]  <= {8'b0, dst[i]} * {8'b0, src[i]};
        s1_pscr_r[i] <= {8'b0, 8'd255 - dst[i]} * {8'b0, 8'd255 - src[i]};
      end
    end
  end

  // ---------------- stage 2: saturating ops, /255 estimates ----------------
  logic            s2_vld_r;
  logic [3:0][7:0] s2_d_r, s2_s_r;
  logic [3:0]      s2_mode_r;
  logic [2:0][7:0] s2_add_r, s2_sub_r, s2_mx_r, s2_mn_r, s2_av_r;
  logic [7:0]      s2_amax_r;
  logic [23:0]     s2_xsa_r;
  logic [16:0]     s2_qsa_r, s2_qda_r;
  logic [2:0][15:0] s2_xmul_r, s2_xscr_r;
  logic [2:0][16:0] s2_qmul_r, s2_qscr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [8:0] sum;
    logic [7:0] sc;
    if (adv) begin
      s2_d_r    <= s1_d_r;
      s2_s_r    <= s1_s_r;
      s2_mode_r <= s1_mode_r;
      s2_amax_r <= (s1_d_r[3] > s1_s_r[3]) ? s1_d_r[3] : s1_s_r[3];
      s2_xsa_r  <= s1_psa_r;
      s2_qsa_r  <= div255_est(s1_psa_r);
      s2_qda_r  <= div255_est({s1_d_r[3], 16'b0});
      for (int i = 0; i < 3; i++) begin
        sc  = s1_pso_r[i][23:16];
        sum = {1'b0, s1_d_r[i]} + {1'b0, sc};
        s2_add_r[i]  <= sum[8] ? 8'd255 : sum[7:0];
        s2_sub_r[i]  <= (s1_d_r[i] > sc) ? s1_d_r[i] - sc : 8'd0;
        s2_mx_r[i]   <= (s1_d_r[i] > s1_s_r[i]) ? s1_d_r[i] : s1_s_r[i];
        s2_mn_r[i]   <= (s1_d_r[i] < s1_s_r[i]) ? s1_d_r[i] : s1_s_r[i];
        sum = {1'b0, s1_d_r[i]} + {1'b0, s1_s_r[i]};
        s2_av_r[i]   <= sum[8:1];
        s2_xmul_r[i] <= s1_pds_r[i];
        s2_xscr_r[i] <= s1_pscr_r[i];
        s2_qmul_r[i] <= div255_est({8'b0, s1_pds_r[i]});
        s2_qscr_r[i] <= div255_est({8'b0, s1_pscr_r[i]});
      end
    end
  end

  // ---------------- stage 3: corrections, mode select ----------------
  logic            s3_vld_r;
  logic [3:0][7:0] s3_d_r, s3_s_r, s3_alt_r;
  logic            s3_nrm_r;
  logic [16:0]     s3_sa_r, s3_da_r;
  logic [2:0][7:0] mul_c, scr_c;
  logic [3:0][7:0] alt_nxt;

  always_comb begin
    logic [16:0] q;
    for (int i = 0; i < 3; i++) begin
      q = div255_fix({8'b0, s2_xmul_r[i]}, s2_qmul_r[i]);
      mul_c[i] = q[7:0];
      q = div255_fix({8'b0, s2_xscr_r[i]}, s2_qscr_r[i]);
      scr_c[i] = 8'd255 - q[7:0];
    end
    alt_nxt = '0;
    alt_nxt[3] = s2_amax_r;
    case (s2_mode_r)
      MODE_ADD:                  alt_nxt[2:0] = s2_add_r;
      MODE_SUBTRACT: begin
        alt_nxt[2:0] = s2_sub_r;
        alt_nxt[3]   = s2_d_r[3];
      end
      MODE_MULTIPLY:             alt_nxt[2:0] = mul_c;
      MODE_SCREEN:               alt_nxt[2:0] = scr_c;
      MODE_MAX, MODE_HIGHLIGHT:  alt_nxt[2:0] = s2_mx_r;
      MODE_MIN, MODE_SHADOW:     alt_nxt[2:0] = s2_mn_r;
      MODE_AVERAGE:              alt_nxt[2:0] = s2_av_r;
      default:                   alt_nxt = s2_d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_d_r   <= s2_d_r;
      s3_s_r   <= s2_s_r;
      s3_alt_r <= alt_nxt;
      s3_nrm_r <= !(s2_mode_r inside {[MODE_ADD:MODE_HIGHLIGHT]});
      s3_sa_r  <= div255_fix(s2_xsa_r, s2_qsa_r);
      s3_da_r  <= div255_fix({s2_d_r[3], 16'b0}, s2_qda_r);
    end
  end

  // ---------------- stage 4: destination weight ----------------
  logic            s4_vld_r;
  logic [3:0][7:0] s4_d_r, s4_s_r, s4_alt_r;
  logic            s4_nrm_r;
  logic [16:0]     s4_sa_r, s4_dw_r;
  logic [33:0]     dw_prod;

  assign dw_prod = {17'b0, s3_da_r} * {17'b0, ONE_Q16 - s3_sa_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_d_r   <= s3_d_r;
      s4_s_r   <= s3_s_r;
      s4_alt_r <= s3_alt_r;
      s4_nrm_r <= s3_nrm_r;
      s4_sa_r  <= s3_sa_r;
      s4_dw_r  <= dw_prod[32:16];
    end
  end

  // ---------------- stage 5: output alpha, weighted colors ----------------
  logic            s5_vld_r;
  logic [3:0][7:0] s5_alt_r;
  logic            s5_nrm_r;
  logic [16:0]     s5_oa_r;
  logic [2:0][23:0] s5_ps_r, s5_pd_r;
  logic [24:0]     ps_c [3];
  logic [24:0]     pd_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps_c[i] = {17'b0, s4_s_r[i]} * {8'b0, s4_sa_r};
      pd_c[i] = {17'b0, s4_d_r[i]} * {8'b0, s4_dw_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_alt_r <= s4_alt_r;
      s5_nrm_r <= s4_nrm_r;
      s5_oa_r  <= s4_sa_r + s4_dw_r;
      for (int i = 0; i < 3; i++) begin
        s5_ps_r[i] <= ps_c[i][23:0];
        s5_pd_r[i] <= pd_c[i][23:0];
      end
    end
  end

  // ---------------- stage 6: numerators and path choice ----------------
  logic            s6_vld_r;
  logic [2:0][24:0] s6_num_r;
  logic [16:0]     s6_oa_r;
  rlb_side_t       s6_side_r;
  logic [24:0]     oa255;

  assign oa255 = {s5_oa_r, 8'b0} - {8'b0, s5_oa_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_oa_r <= s5_oa_r;
      for (int i = 0; i < 3; i++) begin
        s6_num_r[i] <= {1'b0, s5_ps_r[i]} + {1'b0, s5_pd_r[i]};
      end
      s6_side_r.use_div <= s5_nrm_r && (s5_oa_r > ALPHA_EPS_Q16);
      s6_side_r.div_a   <= oa255[24] ? 8'd255 : oa255[23:16];
      s6_side_r.alt     <= s5_alt_r;
    end
  end

  assign out_vld = s6_vld_r;
  assign num     = s6_num_r;
  assign oa      = s6_oa_r;
  assign side    = s6_side_r;

endmodule

// ----- design/rlb_divider.sv -----
// Restoring divider, one quotient bit per register stage, three color lanes.
// Eight stages; depends on rlb_pkg for the side data type.
module rlb_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [2:0][24:0]    num,
  input  logic [16:0]         oa,
  input  rlb_pkg::rlb_side_t  in_side,
  output logic                out_vld,
  output logic [2:0][7:0]     quot,
  output rlb_pkg::rlb_side_t  out_side
);
  import rlb_pkg::*;

  logic             st_vld_r  [8];
  logic [2:0][24:0] st_rem_r  [8];
  logic [2:0][7:0]  st_q_r    [8];
  logic [16:0]      st_oa_r   [8];
  rlb_side_t        st_side_r [8];

  for (genvar g = 0; g < 8; g++) begin : g_stage
    localparam int BIT = 7 - g;
    logic             cur_vld;
    logic [2:0][24:0] cur_rem;
    logic [2:0][7:0]  cur_q;
    logic [16:0]      cur_oa;
    rlb_side_t        cur_side;
    logic [24:0]      dv;
    logic [2:0][24:0] rem_nxt;
    logic [2:0][7:0]  q_nxt;

    if (g == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = num;
      assign cur_q    = '0;
      assign cur_oa   = oa;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = st_vld_r[g-1];
      assign cur_rem  = st_rem_r[g-1];
      assign cur_q    = st_q_r[g-1];
      assign cur_oa   = st_oa_r[g-1];
      assign cur_side = st_side_r[g-1];
    end

    // trial subtract of the shifted divisor
    assign dv = {8'b0, cur_oa} << BIT;
    always_comb begin
      rem_nxt = cur_rem;
      q_nxt   = cur_q;
      for (int i = 0; i < 3; i++) begin
        if (cur_rem[i] >= dv) begin
          rem_nxt[i]    = cur_rem[i] - dv;
          q_nxt[i][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[g] <= 1'b0;
      end else if (adv) begin
        st_vld_r[g] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rem_r[g]  <= rem_nxt;
        st_q_r[g]    <= q_nxt;
        st_oa_r[g]   <= cur_oa;
        st_side_r[g] <= cur_side;
      end
    end
  end

  assign out_vld  = st_vld_r[7];
  assign quot     = st_q_r[7];
  assign out_side = st_side_r[7];

endmodule

// ----- design/rgba_layer_blend_core.sv -----
// RGBA layer blend core: top level with config registers and output register.
// Depends on rlb_pkg, rlb_front, rlb_divider and the assertion macro header.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | in_dst_{red,green,blue,alpha}, in_src_*
//  output   | out_valid/out_stall | out_red, out_green, out_blue, out_alpha
//  config   | cfg_we              | cfg_index, cfg_data
//
// One pixel pair per clock while no output stall holds the pipeline; 6 front stages,
// 8 divider stages and the output register lie between input and output.
// Reset (synchronous, rst_n low) clears all valid bits; mode is normal, opacity 100%.
// A stall on the output freezes the whole pipeline; in_stall is high only while
// the output holds a beat that is being stalled.
module rgba_layer_blend_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  rlb_pkg::px_t      in_dst_red,
  input  rlb_pkg::px_t      in_dst_green,
  input  rlb_pkg::px_t      in_dst_blue,
  input  rlb_pkg::px_t      in_dst_alpha,
  input  rlb_pkg::px_t      in_src_red,
  input  rlb_pkg::px_t      in_src_green,
  input  rlb_pkg::px_t      in_src_blue,
  input  rlb_pkg::px_t      in_src_alpha,
  output logic              out_valid,
  input  logic              out_stall,
  output rlb_pkg::px_t      out_red,
  output rlb_pkg::px_t      out_green,
  output rlb_pkg::px_t      out_blue,
  output rlb_pkg::px_t      out_alpha
);
  import rlb_pkg::*;
`include "rgba_layer_blend_core_assert.svh"

  // configuration: mode and Q1.16 opacity
  logic [3:0]  mode_r;
  logic [16:0] op_r;
  logic [6:0]  pct;
  logic [32:0] op_prod;

  assign pct     = (cfg_data > 7'd100) ? 7'd100 : cfg_data;
  // pct*65536/100 via reciprocal, exact for 0..100
  assign op_prod = {26'b0, pct} * 33'd42949673;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      op_r   <= ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE:  mode_r <= cfg_data[3:0];
        REG_BLEND_VALUE: op_r   <= op_prod[32:16];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the held output is stalled
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic             fr_vld;
  logic [2:0][24:0] fr_num;
  logic [16:0]      fr_oa;
  rlb_side_t        fr_side;

  rlb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .dst     ({in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red}),
    .src     ({in_src_alpha, in_src_blue, in_src_green, in_src_red}),
    .mode    (mode_r),
    .op      (op_r),
    .out_vld (fr_vld),
    .num     (fr_num),
    .oa      (fr_oa),
    .side    (fr_side)
  );

  logic            dv_vld;
  logic [2:0][7:0] dv_q;
  rlb_side_t       dv_side;

  rlb_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .num      (fr_num),
    .oa       (fr_oa),
    .in_side  (fr_side),
    .out_vld  (dv_vld),
    .quot     (dv_q),
    .out_side (dv_side)
  );

  // output register
  logic [3:0][7:0] out_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_px_r <= dv_side.use_div ? {dv_side.div_a, dv_q} : dv_side.alt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_px_r[0];
  assign out_green = out_px_r[1];
  assign out_blue  = out_px_r[2];
  assign out_alpha = out_px_r[3];

  // checks
  `RLB_ASSERT(a_stall_src, clk, rst_n, in_stall |-> (out_valid && out_stall), "stall without held beat")
  `RLB_ASSERT(a_out_load, clk, rst_n, (adv && dv_vld) |=> out_valid, "finished beat lost at output")
  `RLB_ASSERT_ALWAYS(a_reset_clr, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

// ----- tb/rgba_layer_blend_core_tb.sv -----
// Self-checking testbench for rgba_layer_blend_core: directed and random pixel pairs
// across all modes, listed opacities, with random sender gaps and receiver stalls.
// Depends on rlb_pkg and the rgba_layer_blend_core RTL.
module rgba_layer_blend_core_tb;
  import rlb_pkg::*;

  typedef struct packed {
    px_t dr, dg, db, da, sr, sg, sb, sa;
  } pair_t;

  typedef struct packed {
    px_t r, g, b, a;
  } pix_t;

  localparam int LATENCY = 15;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  px_t in_dst_red = '0, in_dst_green = '0, in_dst_blue = '0, in_dst_alpha = '0;
  px_t in_src_red = '0, in_src_green = '0, in_src_blue = '0, in_src_alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  px_t out_red, out_green, out_blue, out_alpha;

  rgba_layer_blend_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_dst_red(in_dst_red), .in_dst_green(in_dst_green),
    .in_dst_blue(in_dst_blue), .in_dst_alpha(in_dst_alpha),
    .in_src_red(in_src_red), .in_src_green(in_src_green),
    .in_src_blue(in_src_blue), .in_src_alpha(in_src_alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the blend registers
  logic [3:0] mode_q = MODE_NORMAL;
  logic [6:0] opacity_pct = 7'd100;

  pair_t pending_pairs[$];
  pix_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int beats_checked = 0;
  int cycle_count = 0;

  // blended pixel for one pair under the current registers
  function automatic pix_t blend_pixel(pair_t p);
    logic [7:0] d[4], s[4];
    logic [31:0] r[4];
    logic [31:0] op, sub, sa, da, dw, oa;
    logic [63:0] num, q;
    pix_t res;
    d = '{p.dr, p.dg, p.db, p.da};
    s = '{p.sr, p.sg, p.sb, p.sa};
    op = ((opacity_pct > 100) ? 32'd100 : 32'(opacity_pct)) * 32'd65536 / 32'd100;
    r[3] = 32'((d[3] > s[3]) ? d[3] : s[3]);
    case (mode_q)
      MODE_ADD:
        for (int i = 0; i < 3; i++) begin
          sub = d[i] + ((s[i] * op) >> 16);
          r[i] = (sub > 255) ? 255 : sub;
        end
      MODE_SUBTRACT: begin
        for (int i = 0; i < 3; i++) begin
          sub = (s[i] * op) >> 16;
          r[i] = (d[i] > sub) ? d[i] - sub : 0;
        end
        r[3] = 32'(d[3]);
      end
      MODE_MULTIPLY:
        for (int i = 0; i < 3; i++) r[i] = (d[i] * s[i]) / 255;
      MODE_SCREEN:
        for (int i = 0; i < 3; i++) r[i] = 255 - ((255 - d[i]) * (255 - s[i])) / 255;
      MODE_MAX, MODE_HIGHLIGHT:
        for (int i = 0; i < 3; i++) r[i] = 32'((d[i] > s[i]) ? d[i] : s[i]);
      MODE_MIN, MODE_SHADOW:
        for (int i = 0; i < 3; i++) r[i] = 32'((d[i] < s[i]) ? d[i] : s[i]);
      MODE_AVERAGE:
        for (int i = 0; i < 3; i++) r[i] = (d[i] + s[i]) / 2;
      default: begin
        // source-over; nearly transparent result passes the destination
        sa = (s[3] * op) / 255;
        da = (d[3] * 32'd65536) / 255;
        dw = 32'((64'(da) * (64'd65536 - sa)) >> 16);
        oa = sa + dw;
        if (oa > 32'(ALPHA_EPS_Q16)) begin
          for (int i = 0; i < 3; i++) begin
            num = 64'(s[i]) * sa + 64'(d[i]) * dw;
            q = num / oa;
            r[i] = (q > 255) ? 255 : 32'(q);
          end
          q = (64'(oa) * 255) >> 16;
          r[3] = (q > 255) ? 255 : 32'(q);
        end else begin
          for (int i = 0; i < 4; i++) r[i] = 32'(d[i]);
        end
      end
    endcase
    res.r = r[0][7:0];
    res.g = r[1][7:0];
    res.b = r[2][7:0];
    res.a = r[3][7:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, px_t got, px_t want);
    $display("MISMATCH %s: got %0d expected %0d (mode %0d, opacity %0d)",
             what, got, want, mode_q, opacity_pct);
    error_count++;
  endtask

  // append one pair to the pending list
  task automatic queue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // driver: presents queued pairs, holding a stalled beat steady
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          expected_pixels.insert(expected_pixels.size(), blend_pixel(p));
          in_valid <= 1'b1;
          {in_dst_red, in_dst_green, in_dst_blue, in_dst_alpha,
           in_src_red, in_src_green, in_src_blue, in_src_alpha} <= p;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: compares each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat, red", out_red, 8'd0);
      end else begin
        pix_t e;
        e = expected_pixels.pop_front();
        if (out_red !== e.r) report_mismatch("red", out_red, e.r);
        if (out_green !== e.g) report_mismatch("green", out_green, e.g);
        if (out_blue !== e.b) report_mismatch("blue", out_blue, e.b);
        if (out_alpha !== e.a) report_mismatch("alpha", out_alpha, e.a);
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic pair_t rand_pair();
    return pair_t'({$urandom, $urandom});
  endfunction

  // wait until every queued and expected beat is done
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_BLEND_MODE) mode_q <= val[3:0];
    else opacity_pct <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int modes_seen;
    logic [6:0] opac_list[6];
    opac_list = '{7'd0, 7'd1, 7'd50, 7'd99, 7'd100, 7'd127};
    modes_seen = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and the transparent case under reset settings
    queue_pair('0);
    queue_pair('1);
    queue_pair({8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd100, 8'd50, 8'd0});
    queue_pair({8'd10, 8'd20, 8'd30, 8'd255, 8'd200, 8'd100, 8'd50, 8'd0});
    queue_pair({8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255});
    queue_pair({8'd1, 8'd2, 8'd3, 8'd0, 8'd4, 8'd5, 8'd6, 8'd1});
    drain();

    // each mode code over the opacity list, idling phases rotated
    for (int m = 0; m < 16; m++) begin
      write_reg(REG_BLEND_MODE, 7'(m));
      for (int k = 0; k < 6; k++) begin
        write_reg(REG_BLEND_VALUE, opac_list[k]);
        case ((m * 6 + k) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
          default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        queue_pair('1);
        queue_pair({8'd200, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd100, 8'd0});
        // more random pixels in the defined modes
        repeat ((m < 10) ? 14 : 4) queue_pair(rand_pair());
        drain();
      end
      modes_seen++;
    end

    // random registers and random pixels to finish off
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_BLEND_MODE, 7'($urandom_range(15)));
      write_reg(REG_BLEND_VALUE, 7'($urandom_range(127)));
      send_idle_pct = (ph % 2) ? 81 : 0;
      recv_stall_pct = (ph % 3 == 0) ? 0 : 81;
      repeat (12) queue_pair(rand_pair());
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    $display("Covered %0d mode codes across opacity extremes; %0d result beats checked",
             modes_seen, beats_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/rlb_pkg.sv
design/rlb_front.sv
design/rlb_divider.sv
design/rgba_layer_blend_core.sv
tb/rgba_layer_blend_core_tb.sv
